// ----- design/lrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lrt_pkg
// shared types and constants of the lru replacement tracker
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int KEY_BITS = 32;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_BITS-1:0] key;
    } t_in;

    typedef struct packed {
        logic                evicted;
        logic [KEY_BITS-1:0] evicted_key;
    } t_out;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ----- design/lrt_ram.sv -----
// ----------------------------------------------------------------------------
// lrt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrt_ctrl
// transaction sequencer: accept, scan the key store, apply the update
// ----------------------------------------------------------------------------
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_sts.out_free) begin
                    cmd.apply = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.apply}))
        else $error("lrt_ctrl: more than one command at once");

endmodule

// ----- design/lrt_dpath.sv -----
// ----------------------------------------------------------------------------
// lrt_dpath
// key store, valid bits, recency ranks, search registers and result register
// ----------------------------------------------------------------------------
module lrt_dpath
    import lrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int OCC_W  = CNT_W;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0]                    r_capacity;
    t_in                                 r_op;
    logic [MAX_ENTRIES-1:0]              r_valid;
    logic [MAX_ENTRIES-1:0][RANK_W-1:0]  r_rank;
    logic [OCC_W-1:0]                    r_occ;

    logic [CNT_W-1:0]    r_addr;
    logic                r_rd_pend;
    logic [IDX_W-1:0]    r_didx;

    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [RANK_W-1:0]   r_hit_rank;
    logic                r_vic_ok;
    logic [IDX_W-1:0]    r_vic_idx;
    logic [RANK_W-1:0]   r_vic_rank;
    logic [KEY_BITS-1:0] r_vic_key;
    logic                r_free_ok;
    logic [IDX_W-1:0]    r_free_idx;

    logic                r_out_valid;
    t_out                r_out;

    logic [MAX_ENTRIES-1:0]              n_valid;
    logic [MAX_ENTRIES-1:0][RANK_W-1:0]  n_rank;
    logic [OCC_W-1:0]                    n_occ;
    t_out                                n_out;

    logic [KEY_BITS-1:0] rdata;
    logic                rd_en;
    logic                d_valid;
    logic [RANK_W-1:0]   d_rank;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [IDX_W-1:0]    ins_idx;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    cap_eff;
    logic                cap_nz;
    logic                occ_full;
    logic                out_free;

    // key store
    assign rd_en = i_cmd.scan && (r_addr != CNT_W'(MAX_ENTRIES));

    lrt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (wr_en && i_cmd.apply),
        .i_waddr (wr_idx),
        .i_wdata (r_op.key),
        .i_re    (rd_en),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign d_valid = r_valid[r_didx];
    assign d_rank  = r_rank[r_didx];

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_sts.out_free  = out_free;
    assign o_sts.scan_done = r_rd_pend && (r_didx == IDX_W'(MAX_ENTRIES - 1));

    // effective capacity
    assign cap_ext  = CMP_W'(r_capacity);
    assign cap_eff  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
    assign cap_nz   = (r_capacity != '0);
    assign occ_full = (CMP_W'(r_occ) >= cap_eff);

    // new slot after an eviction is the lower of the free slot and the victim
    assign ins_idx = (r_free_ok && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        n_out   = '0;
        wr_en   = 1'b0;
        wr_idx  = r_free_idx;
        case (r_op.kind)
            KIND_CLEAR: begin
                n_valid = '0;
                n_rank  = '0;
                n_occ   = '0;
            end
            KIND_ACCESS, KIND_INSERT: begin
                if (r_hit && (r_op.kind == KIND_ACCESS || cap_nz)) begin
                    // promote
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (r_valid[j] && (r_rank[j] < r_hit_rank)) begin
                            n_rank[j] = r_rank[j] + RANK_W'(1);
                        end
                    end
                    n_rank[r_hit_idx] = '0;
                end else if (!r_hit && r_op.kind == KIND_INSERT && cap_nz) begin
                    if (occ_full && r_vic_ok) begin
                        // evict least recent, insert as most recent
                        for (int j = 0; j < MAX_ENTRIES; j++) begin
                            if (r_valid[j] && (r_rank[j] < r_vic_rank)) begin
                                n_rank[j] = r_rank[j] + RANK_W'(1);
                            end
                        end
                        n_valid[r_vic_idx] = 1'b0;
                        n_rank[r_vic_idx]  = '0;
                        n_valid[ins_idx]   = 1'b1;
                        n_rank[ins_idx]    = '0;
                        wr_en              = 1'b1;
                        wr_idx             = ins_idx;
                        n_out.evicted      = 1'b1;
                        n_out.evicted_key  = r_vic_key;
                    end else if (r_free_ok) begin
                        for (int j = 0; j < MAX_ENTRIES; j++) begin
                            if (r_valid[j]) begin
                                n_rank[j] = r_rank[j] + RANK_W'(1);
                            end
                        end
                        n_valid[r_free_idx] = 1'b1;
                        n_rank[r_free_idx]  = '0;
                        n_occ               = r_occ + OCC_W'(1);
                        wr_en               = 1'b1;
                    end
                end
            end
            KIND_ERASE: begin
                if (r_hit) begin
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (r_valid[j] && (r_rank[j] > r_hit_rank)) begin
                            n_rank[j] = r_rank[j] - RANK_W'(1);
                        end
                    end
                    n_valid[r_hit_idx] = 1'b0;
                    n_rank[r_hit_idx]  = '0;
                    if (r_occ != '0) begin
                        n_occ = r_occ - OCC_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_valid     <= '0;
            r_rank      <= '0;
            r_occ       <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_vic_ok    <= 1'b0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end

            if (i_cmd.load) begin
                r_addr    <= '0;
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
                r_vic_ok  <= 1'b0;
                r_free_ok <= 1'b0;
            end

            if (i_cmd.scan) begin
                r_rd_pend <= rd_en;
                if (rd_en) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
                if (r_rd_pend) begin
                    if (d_valid && (rdata == r_op.key) && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (d_valid && (!r_vic_ok || (d_rank > r_vic_rank))) begin
                        r_vic_ok <= 1'b1;
                    end
                    if (!d_valid && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                    end
                end
            end

            if (i_cmd.apply) begin
                r_valid <= n_valid;
                r_rank  <= n_rank;
                r_occ   <= n_occ;
            end

            if (i_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in;
        end
        if (i_cmd.scan) begin
            if (rd_en) begin
                r_didx <= r_addr[IDX_W-1:0];
            end
            if (r_rd_pend) begin
                if (d_valid && (rdata == r_op.key) && !r_hit) begin
                    r_hit_idx  <= r_didx;
                    r_hit_rank <= d_rank;
                end
                if (d_valid && (!r_vic_ok || (d_rank > r_vic_rank))) begin
                    r_vic_idx  <= r_didx;
                    r_vic_rank <= d_rank;
                    r_vic_key  <= rdata;
                end
                if (!d_valid && !r_free_ok) begin
                    r_free_idx <= r_didx;
                end
            end
        end
        if (i_cmd.apply) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("lrt_dpath: occupancy does not match valid bits");

    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= MAX_ENTRIES)
        else $error("lrt_dpath: occupancy above table size");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.evicted |-> r_out.evicted_key == '0)
        else $error("lrt_dpath: evicted key set without eviction");

    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |=> r_out_valid)
        else $error("lrt_dpath: result lost after update");

endmodule

// ----- design/lru_replacement_tracker.sv -----
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// fully associative lru tracker: access, insert with eviction, erase, clear
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  in        i_in_valid / o_in_ready       i_in  (kind, key)
//  out       o_out_valid / i_out_ready     o_out (evicted, evicted_key)
//  cfg       i_cfg_we                      i_cfg_wdata (capacity)
//
//  a transaction runs through accept, a scan of the key ram through its single
//  read port (registered read), and an update
//  synchronous reset clears valid bits, ranks and occupancy; keys are not reset
//  the result waits in an output register while the next transaction is scanned
//  the update cycle waits while the output register is still full
// ----------------------------------------------------------------------------
module lru_replacement_tracker
    import lrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    lrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lrt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru replacement tracker: a queue-fed driver
// offers access, insert, erase and clear transactions with random gaps, a
// monitor stalls the result channel at random and compares every result with
// the output of a cycle-free lru table kept alongside, and capacity changes
// are written only while the tracker is idle
// ----------------------------------------------------------------------------
module testbench
    import lrt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 16;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    typedef enum logic [1:0] {STEP_OP, STEP_CAP, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind       what;
        t_in              op;
        logic [CAP_W-1:0] cap;
    } t_step;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out             o_out;

    t_step op_backlog   [$];
    t_out  result_due_q [$];

    logic [KEY_BITS-1:0] tab_key   [MAX_ENTRIES];
    logic                tab_valid [MAX_ENTRIES];
    logic [3:0]          tab_rank  [MAX_ENTRIES];
    logic [4:0]          tab_count;
    logic [CAP_W-1:0]    cap_model;

    int mismatches   = 0;
    int n_in         = 0;
    int n_out        = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    lru_replacement_tracker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", n_out, what, got, want);
        mismatches++;
    endtask

    function automatic void promote_slot(input int slot);
        logic [3:0] r;
        r = tab_rank[slot];
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (tab_valid[i] && tab_rank[i] < r) tab_rank[i]++;
        tab_rank[slot] = '0;
    endfunction

    function automatic void drop_slot(input int slot);
        logic [3:0] r;
        r = tab_rank[slot];
        tab_valid[slot] = 1'b0;
        tab_rank[slot]  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (tab_valid[i] && tab_rank[i] > r) tab_rank[i]--;
        if (tab_count > 0) tab_count--;
    endfunction

    function automatic t_out track_op(input t_in op);
        t_out       res;
        int         hit;
        int         victim;
        int         slot;
        logic [3:0] best;
        logic [4:0] cap;
        res = '0;
        cap = (cap_model > 5'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) : cap_model;
        hit = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (hit < 0 && tab_valid[i] && tab_key[i] == op.key) hit = i;
        case (op.kind)
            KIND_ACCESS: begin
                if (hit >= 0) promote_slot(hit);
            end
            KIND_INSERT: begin
                if (cap != 0) begin
                    if (hit >= 0) begin
                        promote_slot(hit);
                    end else begin
                        if (tab_count >= cap) begin
                            victim = -1;
                            best   = '0;
                            for (int i = 0; i < MAX_ENTRIES; i++) begin
                                if (tab_valid[i] && (victim < 0 || tab_rank[i] > best)) begin
                                    victim = i;
                                    best   = tab_rank[i];
                                end
                            end
                            if (victim >= 0) begin
                                res.evicted     = 1'b1;
                                res.evicted_key = tab_key[victim];
                                drop_slot(victim);
                            end
                        end
                        slot = -1;
                        for (int i = 0; i < MAX_ENTRIES; i++)
                            if (slot < 0 && !tab_valid[i]) slot = i;
                        if (slot >= 0) begin
                            for (int j = 0; j < MAX_ENTRIES; j++)
                                if (tab_valid[j]) tab_rank[j]++;
                            tab_key[slot]   = op.key;
                            tab_valid[slot] = 1'b1;
                            tab_rank[slot]  = '0;
                            tab_count++;
                        end
                    end
                end
            end
            KIND_ERASE: begin
                if (hit >= 0) drop_slot(hit);
            end
            default: begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    tab_valid[i] = 1'b0;
                    tab_rank[i]  = '0;
                end
                tab_count = '0;
            end
        endcase
        return res;
    endfunction

    task automatic push_op(input logic [1:0] kind, input logic [KEY_BITS-1:0] key);
        t_step s;
        s.what     = STEP_OP;
        s.op.kind  = kind;
        s.op.key   = key;
        s.cap      = '0;
        op_backlog.push_back(s);
    endtask

    task automatic push_cap(input logic [CAP_W-1:0] cap);
        t_step s;
        s.what = STEP_CAP;
        s.op   = '0;
        s.cap  = cap;
        op_backlog.push_back(s);
    endtask

    task automatic push_drain();
        t_step s;
        s.what = STEP_DRAIN;
        s.op   = '0;
        s.cap  = '0;
        op_backlog.push_back(s);
    endtask

    // driver: one transaction at a time from the backlog, capacity writes only when idle
    always @(posedge clk) begin
        logic v_next;
        logic we_next;
        logic idle;
        v_next  = in_valid;
        we_next = 1'b0;
        if (!rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                tab_key[i]   = '0;
                tab_valid[i] = 1'b0;
                tab_rank[i]  = '0;
            end
            tab_count = '0;
            cap_model = CAP_RESET;
            gap_left  = 0;
            v_next    = 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                result_due_q.push_back(track_op(in_data));
                n_in++;
                v_next   = 1'b0;
                gap_left = ((n_in % 300) >= 220) ? 0 : $urandom_range(0, 7);
            end
            idle = (result_due_q.size() == 0) && !o_out_valid;
            if (!v_next && op_backlog.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    case (op_backlog[0].what)
                        STEP_OP: begin
                            in_data <= op_backlog[0].op;
                            v_next = 1'b1;
                            void'(op_backlog.pop_front());
                        end
                        STEP_CAP: begin
                            if (idle) begin
                                cfg_wdata <= op_backlog[0].cap;
                                cap_model = op_backlog[0].cap;
                                we_next   = 1'b1;
                                void'(op_backlog.pop_front());
                            end
                        end
                        default: begin
                            if (idle) void'(op_backlog.pop_front());
                        end
                    endcase
                end
            end
        end
        in_valid <= v_next;
        cfg_we   <= we_next;
    end

    // monitor: random stalls, one long hold-off, compare with the oldest expected result
    always @(posedge clk) begin
        t_out want;
        if (!rst_n) begin
            stall_left = 0;
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (result_due_q.size() == 0) begin
                    report_mismatch("unexpected result, key", o_out.evicted_key, '0);
                end else begin
                    want = result_due_q.pop_front();
                    if (o_out.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(o_out.evicted), 32'(want.evicted));
                    if (o_out.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", o_out.evicted_key, want.evicted_key);
                end
                n_out++;
                if (n_out == HOLD_AT)
                    stall_left = HOLD_CYCLES;
                else
                    stall_left = ((n_out % 256) >= 192) ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [KEY_BITS-1:0] pool [40];
        logic [CAP_W-1:0]    caps [10];
        int                  psize;
        int                  eff;
        int                  r;
        logic [KEY_BITS-1:0] k;
        logic [1:0]          kd;
        caps = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd3, 5'd16};

        // empty table, extreme keys, present-key insert, erase, clear
        push_op(KIND_ACCESS, 32'h0000_1234);
        push_op(KIND_ERASE,  32'h0000_1234);
        push_op(KIND_INSERT, 32'h0000_0000);
        push_op(KIND_INSERT, 32'hFFFF_FFFF);
        push_op(KIND_INSERT, 32'h0000_0000);
        push_op(KIND_ACCESS, 32'hFFFF_FFFF);
        push_op(KIND_ERASE,  32'h0000_0000);
        push_op(KIND_CLEAR,  32'hA5A5_A5A5);
        // eviction order at capacity two
        push_cap(5'd2);
        push_op(KIND_INSERT, 32'h0000_0011);
        push_op(KIND_INSERT, 32'h0000_0022);
        push_op(KIND_INSERT, 32'h0000_0033);
        push_op(KIND_ACCESS, 32'h0000_0022);
        push_op(KIND_INSERT, 32'h0000_0044);
        push_op(KIND_ERASE,  32'h0000_0022);
        push_op(KIND_INSERT, 32'h0000_0055);
        // zero capacity: no insert and no refresh
        push_cap(5'd0);
        push_op(KIND_INSERT, 32'h0000_0066);
        push_op(KIND_INSERT, 32'h0000_0044);
        push_op(KIND_ACCESS, 32'h5A5A_5A5A);
        push_cap(5'd2);
        push_op(KIND_INSERT, 32'h0000_0077);
        push_op(KIND_CLEAR,  32'h0000_0000);

        for (int p = 0; p < 10; p++) begin
            push_cap(caps[p]);
            eff   = (caps[p] > 5'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(caps[p]);
            psize = eff + 1 + $urandom_range(0, eff + 3);
            for (int i = 0; i < psize; i++) pool[i] = $urandom;
            for (int n = 0; n < 165; n++) begin
                if (p == 3 && n == 80) push_drain();
                r  = $urandom_range(0, 99);
                kd = (r < 45) ? KIND_INSERT : (r < 73) ? KIND_ACCESS :
                     (r < 97) ? KIND_ERASE : KIND_CLEAR;
                k  = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, psize - 1)];
                push_op(kd, k);
            end
            // fill up so the next, smaller capacity starts below occupancy
            if (p == 0)
                for (int n = 0; n < 20; n++) push_op(KIND_INSERT, $urandom);
        end

        while (op_backlog.size() != 0 || in_valid || result_due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (result_due_q.size() != 0)
            report_mismatch("results still due", result_due_q.size(), '0);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
